// ===== hdl/olmr_pkg.sv =====
// Package for the ordered list with move and rank queries.
// Holds the field widths, command codes, state codes and the cell command bundle.
// No dependencies.
package olmr_pkg;

	// Width of one stored item and of the answer.
	localparam int ITEM_W = 9;
	// Index width that covers the largest supported list (4096 positions).
	localparam int POS_IDX_W = 12;
	// Count width that can hold the list length itself.
	localparam int CNT_W = POS_IDX_W + 1;

	// Command codes carried by the mode field.
	typedef enum logic [2:0] {
		MODE_LOAD   = 3'd0,
		MODE_TOP    = 3'd1,
		MODE_BOTTOM = 3'd2,
		MODE_SHIFT  = 3'd3,
		MODE_POS_Q  = 3'd4,
		MODE_ITEM_Q = 3'd5
	} mode_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MOVE,
		ST_DONE
	} state_t;

	// Command bundle broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                 load_en;
		logic [POS_IDX_W-1:0] load_idx;
		logic [ITEM_W-1:0]    load_val;
		logic                 move_en;
		logic                 move_up;
		logic [POS_IDX_W-1:0] move_from;
		logic [POS_IDX_W-1:0] move_to;
		logic [ITEM_W-1:0]    move_val;
		logic                 key_by_pos;
		logic                 key_pos_ok;
		logic [POS_IDX_W-1:0] key_idx;
		logic                 key_item_ok;
		logic [ITEM_W-1:0]    key_item;
		logic [CNT_W-1:0]     key_lim;
	} cell_cmd_t;

endpackage

// ===== hdl/ordered_list_move_rank.sv =====
// Top level of the ordered list with move and rank queries.
// Instantiates one olmr_cell per position and the olmr_tree search; depends on olmr_pkg.
//
//   port group                    | dir | transfer
//   ------------------------------+-----+---------------------------------------
//   in_valid/in_ready + command   | in  | word taken when in_valid && in_ready
//   out_valid/out_ready + answer  | out | word taken when out_valid && out_ready
//   cfg_we/cfg_wdata              | in  | item_count written when cfg_we is high
//
// A load, or a word with an unused mode, needs no search and leaves in_ready high. A query
// or a move waits on the registered priority tree that finds the item or position, so
// its time to the next accepted word is set by the tree's depth; a top, bottom or shift that
// finds no item, or a shift by zero, returns to idle without a move. A query's answer passes
// through the answer register into the output register, which raises out_valid.
// A move then slides the whole range between source and destination at once, in the move state.
// One command is worked on at a time; a query waits in its last state while the
// previous answer is still held in the output register. Reset clears control state
// only; list entries are undefined until loaded.
module ordered_list_move_rank import olmr_pkg::*; #(
	parameter int MAX_ITEMS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               mode,
	input  logic [ITEM_W-1:0]        item,
	input  logic [ITEM_W-1:0]        position,
	input  logic signed [ITEM_W-1:0] offset,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ITEM_W-1:0]        answer,
	input  logic                     cfg_we,
	input  logic [ITEM_W-1:0]        cfg_wdata
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int LV = IW;
	localparam int CW = $clog2(LV + 1);
	localparam int SW = CNT_W + 1;

	state_t                   state_q, state_d;
	logic [CW-1:0]            cnt_q;
	logic [ITEM_W-1:0]        item_count_q;
	mode_t                    mode_q;
	logic [ITEM_W-1:0]        item_q;
	logic [ITEM_W-1:0]        pos_q;
	logic                     pos_ok_q;
	logic signed [ITEM_W-1:0] offset_q;
	logic                     move_up_q;
	logic [POS_IDX_W-1:0]     from_q, to_q;
	logic [ITEM_W-1:0]        ans_q;
	logic                     out_valid_q;

	logic [CNT_W-1:0]         n_cnt;
	logic [31:0]              ic_ext;
	logic                     in_acc;
	logic                     in_pos_ok;
	logic                     start_search;
	logic                     take_move;
	logic                     take_ans;
	logic                     load_out;
	logic [ITEM_W-1:0]        ans_d;
	logic [POS_IDX_W-1:0]     to_d;
	logic signed [SW-1:0]     dst_s;
	logic signed [SW-1:0]     last_s;

	cell_cmd_t                cmd;
	logic [ITEM_W-1:0]        val_w [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]     hit_w;
	logic                     root_hit;
	logic [IW-1:0]            root_idx;
	logic [ITEM_W-1:0]        root_val;

	// Effective list length, saturated into 1..MAX_ITEMS.
	always_comb begin
		ic_ext = 32'(item_count_q);
		if (ic_ext == 32'd0) begin
			n_cnt = CNT_W'(1);
		end else if (ic_ext > 32'(MAX_ITEMS)) begin
			n_cnt = CNT_W'(MAX_ITEMS);
		end else begin
			n_cnt = CNT_W'(ic_ext);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign in_pos_ok = (position != '0) && (CNT_W'(position) <= n_cnt);

	// Destination of a move: the shift target clamped into the list, the first position for top, the last for bottom.
	always_comb begin
		dst_s  = $signed(SW'(root_idx)) + SW'(offset_q);
		last_s = $signed(SW'(n_cnt - CNT_W'(1)));
		if (dst_s < 0) begin
			to_d = '0;
		end else if (dst_s > last_s) begin
			to_d = POS_IDX_W'(last_s);
		end else begin
			to_d = POS_IDX_W'(dst_s);
		end
		case (mode_q)
			MODE_TOP:    to_d = '0;
			MODE_BOTTOM: to_d = POS_IDX_W'(n_cnt - CNT_W'(1));
			default:     ;
		endcase
	end

	// Next state and control strobes.
	always_comb begin
		state_d      = state_q;
		start_search = 1'b0;
		take_move    = 1'b0;
		take_ans     = 1'b0;
		load_out     = 1'b0;
		ans_d        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (mode_t'(mode))
						MODE_TOP, MODE_BOTTOM, MODE_SHIFT, MODE_POS_Q, MODE_ITEM_Q: begin
							state_d      = ST_SEARCH;
							start_search = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_SEARCH: begin
				if (cnt_q == '0) begin
					case (mode_q)
						MODE_POS_Q: begin
							ans_d    = root_hit ? ITEM_W'(root_idx) : '0;
							take_ans = 1'b1;
							state_d  = ST_DONE;
						end
						MODE_ITEM_Q: begin
							ans_d    = root_hit ? root_val : '0;
							take_ans = 1'b1;
							state_d  = ST_DONE;
						end
						MODE_TOP, MODE_BOTTOM: begin
							take_move = root_hit;
							state_d   = root_hit ? ST_MOVE : ST_IDLE;
						end
						MODE_SHIFT: begin
							take_move = root_hit && (offset_q != '0);
							state_d   = take_move ? ST_MOVE : ST_IDLE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MOVE: begin
				state_d = ST_IDLE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: tree wait counter, configuration and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			item_count_q <= ITEM_W'(256);
			out_valid_q  <= 1'b0;
		end else begin
			if (start_search) begin
				cnt_q <= CW'(LV);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cfg_we) begin
				item_count_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command, move and answer registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= mode_t'(mode);
			item_q   <= item;
			pos_q    <= position;
			pos_ok_q <= in_pos_ok;
			offset_q <= offset;
		end
		if (take_move) begin
			from_q    <= POS_IDX_W'(root_idx);
			to_q      <= to_d;
			move_up_q <= POS_IDX_W'(root_idx) < to_d;
		end
		if (take_ans) begin
			ans_q <= ans_d;
		end
		if (load_out) begin
			answer <= ans_q;
		end
	end

	assign out_valid = out_valid_q;

	// Command broadcast to the cells.
	always_comb begin
		cmd.load_en     = in_acc && (mode_t'(mode) == MODE_LOAD) && in_pos_ok;
		cmd.load_idx    = POS_IDX_W'(position) - POS_IDX_W'(1);
		cmd.load_val    = item;
		cmd.move_en     = (state_q == ST_MOVE);
		cmd.move_up     = move_up_q;
		cmd.move_from   = from_q;
		cmd.move_to     = to_q;
		cmd.move_val    = item_q;
		cmd.key_by_pos  = (mode_q == MODE_ITEM_Q);
		cmd.key_pos_ok  = pos_ok_q;
		cmd.key_idx     = POS_IDX_W'(pos_q) - POS_IDX_W'(1);
		cmd.key_item_ok = (item_q != '0);
		cmd.key_item    = item_q;
		cmd.key_lim     = n_cnt;
	end

	// Row of position cells, each linked to its two neighbors.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [ITEM_W-1:0] up_w, dn_w;
		if (i + 1 < MAX_ITEMS) begin : g_up
			assign up_w = val_w[i+1];
		end else begin : g_up_end
			assign up_w = '0;
		end
		if (i > 0) begin : g_dn
			assign dn_w = val_w[i-1];
		end else begin : g_dn_end
			assign dn_w = '0;
		end
		olmr_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.val_up (up_w),
			.val_dn (dn_w),
			.val    (val_w[i]),
			.hit    (hit_w[i])
		);
	end

	// Lowest-index match search.
	olmr_tree #(
		.N(MAX_ITEMS)
	) u_tree (
		.clk      (clk),
		.leaf_hit (hit_w),
		.leaf_val (val_w),
		.root_hit (root_hit),
		.root_idx (root_idx),
		.root_val (root_val)
	);

endmodule

// ===== hdl/olmr_cell.sv =====
// One position cell of the ordered list: holds the item at its position.
// Loads, takes a neighbor's item during a move, and flags a search match.
// Depends on olmr_pkg.
module olmr_cell import olmr_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [ITEM_W-1:0] val_up,
	input  logic [ITEM_W-1:0] val_dn,
	output logic [ITEM_W-1:0] val,
	output logic              hit
);

	localparam logic [POS_IDX_W-1:0] ID = POS_IDX_W'(IDX);

	logic [ITEM_W-1:0] val_q;

	// Entry update: a load, or one step of a range slide.
	always_ff @(posedge clk) begin
		if (cmd.load_en && (cmd.load_idx == ID)) begin
			val_q <= cmd.load_val;
		end else if (cmd.move_en) begin
			if (ID == cmd.move_to) begin
				val_q <= cmd.move_val;
			end else if (cmd.move_up && (ID >= cmd.move_from) && (ID < cmd.move_to)) begin
				val_q <= val_up;
			end else if (!cmd.move_up && (ID > cmd.move_to) && (ID <= cmd.move_from)) begin
				val_q <= val_dn;
			end
		end
	end

	// Match flag: by position for the item-at query, by item otherwise.
	always_comb begin
		if (cmd.key_by_pos) begin
			hit = cmd.key_pos_ok && (ID == cmd.key_idx);
		end else begin
			hit = cmd.key_item_ok && (val_q == cmd.key_item) && ({1'b0, ID} < cmd.key_lim);
		end
	end

	assign val = val_q;

endmodule

// ===== hdl/olmr_tree.sv =====
// Registered priority tree over the cell match flags.
// Each level picks the lower-indexed flagged entry; the root carries its index and item.
// Depends on olmr_pkg.
module olmr_tree import olmr_pkg::*; #(
	parameter int N = 256
) (
	input  logic                     clk,
	input  logic [N-1:0]             leaf_hit,
	input  logic [ITEM_W-1:0]        leaf_val [N],
	output logic                     root_hit,
	output logic [$clog2(N)-1:0]     root_idx,
	output logic [ITEM_W-1:0]        root_val
);

	localparam int IW = $clog2(N);
	localparam int P  = 1 << IW;

	typedef struct packed {
		logic              hit;
		logic [IW-1:0]     idx;
		logic [ITEM_W-1:0] val;
	} node_t;

	node_t leaf_n [P];
	node_t tree_q [1:P-1];

	// Leaves, padded with empty entries up to a power of two.
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_used
			assign leaf_n[i] = '{hit: leaf_hit[i], idx: IW'(i), val: leaf_val[i]};
		end else begin : g_pad
			assign leaf_n[i] = '{hit: 1'b0, idx: IW'(i), val: '0};
		end
	end

	// Internal nodes in heap order; node 1 is the root. Left child wins a tie.
	for (genvar k = 1; k < P; k++) begin : g_node
		if (2 * k >= P) begin : g_bottom
			always_ff @(posedge clk) begin
				tree_q[k] <= leaf_n[2*k-P].hit ? leaf_n[2*k-P] : leaf_n[2*k+1-P];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				tree_q[k] <= tree_q[2*k].hit ? tree_q[2*k] : tree_q[2*k+1];
			end
		end
	end

	assign root_hit = tree_q[1].hit;
	assign root_idx = tree_q[1].idx;
	assign root_val = tree_q[1].val;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for ordered_list_move_rank: directed words, count limits and
// random traffic, checked against a behavioral list model kept in this file.
// Depends on olmr_pkg and the ordered_list_move_rank RTL.
module tb_top;
	import olmr_pkg::*;

	localparam int LIST_DEPTH = 256;
	localparam int SETTLE_CYCLES = 24;
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [2:0]               mode;
	logic [ITEM_W-1:0]        item;
	logic [ITEM_W-1:0]        position;
	logic signed [ITEM_W-1:0] offset;
	logic                     out_valid;
	logic                     out_ready;
	logic [ITEM_W-1:0]        answer;
	logic                     cfg_we;
	logic [ITEM_W-1:0]        cfg_wdata;

	// Model of the list: item at each 1-based position, which positions were loaded,
	// and the configured count.
	logic [ITEM_W-1:0] order_q [1:LIST_DEPTH];
	bit                loaded_q [1:LIST_DEPTH];
	logic [ITEM_W-1:0] count_reg;
	logic [ITEM_W-1:0] answers_due [$];
	logic [ITEM_W-1:0] due_answer;
	int                mismatches;
	int                tx_idle;
	int                rx_idle;

	ordered_list_move_rank i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.item      (item),
		.position  (position),
		.offset    (offset),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.answer    (answer),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Number of positions in use: the register saturated into 1..LIST_DEPTH.
	function automatic int list_len();
		if (count_reg == 0) return 1;
		if (count_reg > LIST_DEPTH) return LIST_DEPTH;
		return int'(count_reg);
	endfunction

	// Lowest position holding the item, or 0 when absent; item zero never matches.
	function automatic int rank_of(logic [ITEM_W-1:0] it, int n);
		if (it == 0) return 0;
		for (int p = 1; p <= n; p++) begin
			if (order_q[p] == it) return p;
		end
		return 0;
	endfunction

	// Move one entry and slide everything in between by one place.
	function automatic void slide_entry(int from, int to);
		logic [ITEM_W-1:0] held;
		held = order_q[from];
		if (from < to) begin
			for (int p = from; p < to; p++) order_q[p] = order_q[p + 1];
		end else begin
			for (int p = from; p > to; p--) order_q[p] = order_q[p - 1];
		end
		order_q[to] = held;
	endfunction

	// Update the list model for one accepted word and queue its answer, if any.
	function automatic void apply_command(logic [2:0] m, logic [ITEM_W-1:0] it,
			logic [ITEM_W-1:0] pos, logic signed [ITEM_W-1:0] off);
		int n;
		int cur;
		int dst;
		n = list_len();
		case (m)
			MODE_LOAD: begin
				if (pos >= 1 && pos <= n) begin
					order_q[pos] = it;
					loaded_q[pos] = 1'b1;
				end
			end
			MODE_TOP, MODE_BOTTOM, MODE_SHIFT: begin
				cur = rank_of(it, n);
				if (cur != 0) begin
					if (m == MODE_TOP) dst = 1;
					else if (m == MODE_BOTTOM) dst = n;
					else begin
						dst = cur + int'(off);
						if (dst < 1) dst = 1;
						if (dst > n) dst = n;
					end
					slide_entry(cur, dst);
				end
			end
			MODE_POS_Q: begin
				cur = rank_of(it, n);
				answers_due.push_back((cur == 0) ? '0 : ITEM_W'(cur - 1));
			end
			MODE_ITEM_Q: begin
				answers_due.push_back((pos >= 1 && pos <= n) ? order_q[pos] : '0);
			end
			default: ;
		endcase
	endfunction

	// Offer one word, idling first at the current sender rate, and hold it until taken.
	task automatic send_word(logic [2:0] m, logic [ITEM_W-1:0] it, logic [ITEM_W-1:0] pos,
			logic signed [ITEM_W-1:0] off);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		item <= it;
		position <= pos;
		offset <= off;
		do @(posedge clk); while (!in_ready);
		apply_command(m, it, pos, off);
	endtask

	// Stop sending, wait for every answer, then let a command without an answer finish.
	task automatic drain_all();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the count register while the block is idle.
	task automatic set_count(logic [ITEM_W-1:0] value);
		drain_all();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = value;
	endtask

	// Load every position in use that was never written, mostly with a shuffled set.
	task automatic fill_unloaded();
		int pool [LIST_DEPTH];
		int j;
		int tmp;
		int n;
		n = list_len();
		for (int i = 0; i < LIST_DEPTH; i++) pool[i] = i + 1;
		for (int i = LIST_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = pool[i];
			pool[i] = pool[j];
			pool[j] = tmp;
		end
		for (int p = 1; p <= n; p++) begin
			if (!loaded_q[p]) begin
				if ($urandom_range(0, 19) == 0)
					send_word(MODE_LOAD, ITEM_W'($urandom_range(0, 511)), ITEM_W'(p), '0);
				else
					send_word(MODE_LOAD, ITEM_W'(pool[p - 1]), ITEM_W'(p), '0);
			end
		end
	endtask

	// Short list of six: every command, clamping, absent items and unused modes.
	task automatic test_directed_cases();
		set_count(9'd6);
		send_word(MODE_LOAD, 9'd1, 9'd1, '0);
		send_word(MODE_LOAD, 9'd256, 9'd2, '0);
		send_word(MODE_LOAD, 9'd511, 9'd3, '0);
		send_word(MODE_LOAD, 9'd40, 9'd4, '0);
		send_word(MODE_LOAD, 9'd50, 9'd5, '0);
		send_word(MODE_LOAD, 9'd60, 9'd6, '0);
		// Loads outside the list are dropped.
		send_word(MODE_LOAD, 9'd99, 9'd0, '0);
		send_word(MODE_LOAD, 9'd99, 9'd7, '0);
		send_word(MODE_TOP, 9'd60, '0, '0);
		send_word(MODE_BOTTOM, 9'd60, '0, '0);
		send_word(MODE_SHIFT, 9'd1, '0, 9'sd2);
		// Shifts past either end clamp to the first or last position.
		send_word(MODE_SHIFT, 9'd256, '0, -9'sd256);
		send_word(MODE_SHIFT, 9'd50, '0, 9'sd255);
		send_word(MODE_SHIFT, 9'd40, '0, '0);
		// Absent items and item zero leave the list alone.
		send_word(MODE_TOP, 9'd300, '0, '0);
		send_word(MODE_BOTTOM, 9'd0, '0, '0);
		send_word(MODE_POS_Q, 9'd60, '0, '0);
		send_word(MODE_POS_Q, 9'd1, '0, '0);
		send_word(MODE_POS_Q, 9'd0, '0, '0);
		send_word(MODE_POS_Q, 9'd300, '0, '0);
		send_word(MODE_ITEM_Q, '0, 9'd1, '0);
		send_word(MODE_ITEM_Q, '0, 9'd6, '0);
		send_word(MODE_ITEM_Q, '0, 9'd0, '0);
		send_word(MODE_ITEM_Q, '0, 9'd7, '0);
		send_word(MODE_SPARE_A, 9'd1, 9'd1, 9'sd1);
		send_word(MODE_SPARE_B, 9'd511, 9'd511, -9'sd1);
	endtask

	// Counts of zero and one both leave a single position in use.
	task automatic test_count_limits();
		logic [ITEM_W-1:0] settings [2];
		settings[0] = 9'd0;
		settings[1] = 9'd1;
		foreach (settings[k]) begin
			set_count(settings[k]);
			send_word(MODE_LOAD, 9'd0, 9'd1, '0);
			send_word(MODE_POS_Q, 9'd0, '0, '0);
			send_word(MODE_ITEM_Q, '0, 9'd1, '0);
			send_word(MODE_LOAD, 9'd5, 9'd1, '0);
			send_word(MODE_TOP, 9'd5, '0, '0);
			send_word(MODE_BOTTOM, 9'd5, '0, '0);
			send_word(MODE_SHIFT, 9'd5, '0, 9'sd7);
			send_word(MODE_POS_Q, 9'd5, '0, '0);
			send_word(MODE_ITEM_Q, '0, 9'd2, '0);
		end
	endtask

	// Random commands on a fully loaded list, mostly naming items that are present.
	task automatic test_random_traffic(int tx_pct, int rx_pct, logic [ITEM_W-1:0] count,
			int words);
		int n;
		int pick;
		int nudge;
		logic [2:0] m;
		logic [ITEM_W-1:0] it;
		logic [ITEM_W-1:0] pos;
		logic signed [ITEM_W-1:0] off;
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		set_count(count);
		fill_unloaded();
		n = list_len();
		for (int w = 0; w < words; w++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) m = MODE_LOAD;
			else if (pick < 26) m = MODE_TOP;
			else if (pick < 38) m = MODE_BOTTOM;
			else if (pick < 58) m = MODE_SHIFT;
			else if (pick < 76) m = MODE_POS_Q;
			else if (pick < 94) m = MODE_ITEM_Q;
			else m = (pick < 97) ? MODE_SPARE_A : MODE_SPARE_B;
			if (m == MODE_LOAD)
				it = ($urandom_range(0, 9) == 0) ? ITEM_W'($urandom_range(0, 511))
					: ITEM_W'($urandom_range(1, 256));
			else if ($urandom_range(0, 99) < 85)
				it = order_q[$urandom_range(1, n)];
			else
				it = ITEM_W'($urandom_range(0, 511));
			pos = ($urandom_range(0, 99) < 85) ? ITEM_W'($urandom_range(1, n))
				: ITEM_W'($urandom_range(0, 511));
			if ($urandom_range(0, 1) == 0) begin
				nudge = $urandom_range(0, 8) - 4;
				off = nudge[ITEM_W-1:0];
			end else begin
				off = ITEM_W'($urandom_range(0, 511));
			end
			send_word(m, it, pos, off);
			// Now and then hold off until every answer is back.
			if ($urandom_range(0, 99) < 2) drain_all();
		end
	endtask

	// The receiver takes an answer word at its current rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// Compare each answer word with the oldest expected answer.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: answer with none expected, expected none actual %0d",
					$time, answer);
				mismatches++;
			end else begin
				due_answer = answers_due.pop_front();
				if (answer !== due_answer) begin
					$display("%0t: answer mismatch, expected %0d actual %0d",
						$time, due_answer, answer);
					mismatches++;
				end
			end
		end
	end

	initial begin
		in_valid <= 1'b0;
		mode <= MODE_LOAD;
		item <= '0;
		position <= '0;
		offset <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		mismatches = 0;
		tx_idle = 29;
		rx_idle = 66;
		count_reg = 9'd256;
		foreach (loaded_q[p]) loaded_q[p] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_count_limits();
		test_random_traffic(29, 66, 9'd511, 420);
		test_random_traffic(66, 29, ITEM_W'($urandom_range(2, 40)), 420);
		test_random_traffic(0, 0, 9'd256, 420);

		drain_all();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
